// File: hw/rtl/rpd_pkg.sv
// Package for the run-length pixel decoder.
// Shared codes, header constants and the structs passed between the core and the top level.
// No dependencies.
package rpd_pkg;

   localparam int unsigned PIXEL_W  = 32;
   localparam int unsigned REPEAT_W = 8;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned BPP_W    = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // item opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLIPPED = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_PIXELS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_LIMIT    = 2'd2;

   localparam logic [BPP_W-1:0]   BPP_RESET     = 3'd3;
   localparam logic [COUNT_W-1:0] PIXELS_RESET  = '0;
   localparam logic [COUNT_W-1:0] LIMIT_RESET   = '0;

   // packet header fields
   localparam logic [7:0] HDR_RUN_BIT  = 8'h80;
   localparam logic [7:0] HDR_LEN_MASK = 8'h7f;

   typedef struct packed {
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [COUNT_W-1:0] image_pixels;
      logic [COUNT_W-1:0] source_limit;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [PIXEL_W-1:0]  pixel_value;
      logic [REPEAT_W-1:0] repeat_count;
      logic                image_done;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// File: hw/rtl/rpd_core.sv
// Decode core of the run-length pixel decoder: packet state and per-byte next-state logic.
// Produces at most one result per accepted item, combinationally from the current state.
// Depends on rpd_pkg.
module rpd_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  logic               item_op,
   input  logic [7:0]         item_data,
   input  rpd_pkg::cfg_type   cfg,
   output rpd_pkg::result_type result
);
   import rpd_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_RUN     = 2'd2;
   localparam logic [1:0] PH_STOPPED = 2'd3;

   logic [1:0]          phase_ff, phase_in;
   logic [REPEAT_W-1:0] packet_left_ff, packet_left_in;
   logic [1:0]          byte_slot_ff, byte_slot_in;
   logic [PIXEL_W-1:0]  pixel_acc_ff, pixel_acc_in;
   logic [COUNT_W-1:0]  pixels_done_ff, pixels_done_in;
   logic [COUNT_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic                clip_ff, clip_in;

   logic [BPP_W-1:0]    width;
   logic [PIXEL_W-1:0]  acc_merged;
   logic [1:0]          slot_next;
   logic [REPEAT_W-1:0] cnt;
   logic [COUNT_W-1:0]  remaining;
   logic [REPEAT_W-1:0] rep;
   logic [REPEAT_W-1:0] left_next;
   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  done_count;

   // out-of-range widths clamp to 1..4
   function automatic logic [BPP_W-1:0] pixel_width(input logic [BPP_W-1:0] bpp);
      if (bpp == '0) begin
         return 3'd1;
      end
      if (bpp > 3'd4) begin
         return 3'd4;
      end
      return bpp;
   endfunction

   assign width = pixel_width(cfg.bytes_per_pixel);

   always_comb begin
      case (byte_slot_ff)
         2'd0:    acc_merged = pixel_acc_ff | {24'b0, item_data};
         2'd1:    acc_merged = pixel_acc_ff | {16'b0, item_data, 8'b0};
         2'd2:    acc_merged = pixel_acc_ff | {8'b0, item_data, 16'b0};
         default: acc_merged = pixel_acc_ff | {item_data, 24'b0};
      endcase
   end

   assign slot_next = byte_slot_ff + 2'd1;
   assign remaining = cfg.image_pixels - pixels_done_ff;
   assign cnt       = {1'b0, item_data[6:0] & HDR_LEN_MASK[6:0]} + 8'd1;
   assign rep       = (phase_ff == PH_RUN) ? packet_left_ff : 8'd1;
   assign left_next = (phase_ff == PH_RUN || packet_left_ff == '0) ? '0
                                                                  : packet_left_ff - 8'd1;
   assign sum        = {1'b0, pixels_done_ff} + {{(COUNT_W+1-REPEAT_W){1'b0}}, rep};
   assign done_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

   always_comb begin
      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      byte_slot_in   = byte_slot_ff;
      pixel_acc_in   = pixel_acc_ff;
      pixels_done_in = pixels_done_ff;
      bytes_seen_in  = bytes_seen_ff;
      clip_in        = clip_ff;
      result         = '0;

      if (item_valid) begin
         if (item_op == OP_START) begin
            phase_in       = PH_HEADER;
            packet_left_in = '0;
            byte_slot_in   = '0;
            pixel_acc_in   = '0;
            pixels_done_in = '0;
            bytes_seen_in  = '0;
            clip_in        = 1'b0;
         end else if (phase_ff != PH_STOPPED && pixels_done_ff < cfg.image_pixels) begin
            if (bytes_seen_ff >= cfg.source_limit) begin
               // byte is not consumed; block halts until next start
               phase_in      = PH_STOPPED;
               result.valid  = 1'b1;
               result.status = ST_OVERRUN;
            end else begin
               bytes_seen_in = bytes_seen_ff + 32'd1;
               if (phase_ff == PH_HEADER) begin
                  if ({24'b0, cnt} > remaining) begin
                     packet_left_in = remaining[REPEAT_W-1:0];
                     clip_in        = 1'b1;
                  end else begin
                     packet_left_in = cnt;
                     clip_in        = 1'b0;
                  end
                  byte_slot_in = '0;
                  pixel_acc_in = '0;
                  phase_in     = ((item_data & HDR_RUN_BIT) != '0) ? PH_RUN : PH_LITERAL;
               end else if (slot_next != 2'd0 && {1'b0, slot_next} < width) begin
                  pixel_acc_in = acc_merged;
                  byte_slot_in = slot_next;
               end else begin
                  packet_left_in      = left_next;
                  pixels_done_in      = done_count;
                  result.valid        = 1'b1;
                  result.pixel_value  = acc_merged;
                  result.repeat_count = rep;
                  result.status       = clip_ff ? ST_CLIPPED : ST_OK;
                  if (done_count >= cfg.image_pixels) begin
                     result.image_done = 1'b1;
                     phase_in          = PH_STOPPED;
                  end else if (left_next == '0) begin
                     phase_in = PH_HEADER;
                     clip_in  = 1'b0;
                  end
                  pixel_acc_in = '0;
                  byte_slot_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         packet_left_ff <= '0;
         byte_slot_ff   <= '0;
         pixel_acc_ff   <= '0;
         pixels_done_ff <= '0;
         bytes_seen_ff  <= '0;
         clip_ff        <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         byte_slot_ff   <= byte_slot_in;
         pixel_acc_ff   <= pixel_acc_in;
         pixels_done_ff <= pixels_done_in;
         bytes_seen_ff  <= bytes_seen_in;
         clip_ff        <= clip_in;
      end
   end

endmodule

// File: hw/rtl/rle_pixel_decoder_unit.sv
// Run-length pixel decoder, top level: configuration registers, decode core, result register.
// Depends on rpd_pkg and rpd_core.
//
// Usage:
//   req_*  : one item per accept (req_valid high, req_stall low). op 0 starts a new
//            image and clears all counters; op 1 carries one compressed byte.
//   rsp_*  : at most one result per item: a pixel with its repeat count, an image
//            done flag and a status (ok, source overrun, packet clipped).
//   csr_*  : write-only registers, written while the block is idle: bytes per pixel,
//            image pixel count, source byte limit.
// Latency: a result appears on rsp_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle while req_stall is low; all per-byte work is one pass through
//   the core's next-state logic, the longest path being the pixel count add and its compare.
// Stall: while a result is held with rsp_stall high, req_stall is raised; the
//   result register frees and takes a new item in the same cycle it is drained.
// Reset: registers return to 3 bytes per pixel, zero pixels, zero limit; the
//   decoder waits for a packet header with all counters cleared.
module rle_pixel_decoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rpd_pkg::PIXEL_W-1:0]     rsp_pixel_value,
   output logic [rpd_pkg::REPEAT_W-1:0]    rsp_repeat_count,
   output logic                            rsp_image_done,
   output logic [rpd_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                            csr_write,
   input  logic [rpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpd_pkg::COUNT_W-1:0]     csr_data
);
   import rpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type core_result;
   logic       req_accept;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  pixel_ff;
   logic [REPEAT_W-1:0] repeat_ff;
   logic                done_ff;
   logic [STATUS_W-1:0] status_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_data[BPP_W-1:0];
            CSR_IMAGE_PIXELS:    cfg_in.image_pixels    = csr_data;
            CSR_SOURCE_LIMIT:    cfg_in.source_limit    = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   rpd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_accept),
      .item_op    (req_op),
      .item_data  (req_data_byte),
      .cfg        (cfg_ff),
      .result     (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = core_result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= BPP_RESET;
         cfg_ff.image_pixels    <= PIXELS_RESET;
         cfg_ff.source_limit    <= LIMIT_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && core_result.valid) begin
         pixel_ff  <= core_result.pixel_value;
         repeat_ff <= core_result.repeat_count;
         done_ff   <= core_result.image_done;
         status_ff <= core_result.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = pixel_ff;
   assign rsp_repeat_count = repeat_ff;
   assign rsp_image_done   = done_ff;
   assign rsp_status       = status_ff;

   // overrun results carry no pixel and never finish the image
   a_overrun_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERRUN |-> rsp_repeat_count == '0 && !rsp_image_done)
      else $error("overrun result with pixel fields set");

   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OVERRUN |-> rsp_repeat_count != '0)
      else $error("pixel result with zero repeat count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_OVERRUN
                    || rsp_status == ST_CLIPPED)
      else $error("undefined status code");

   // a held result must block new items so it is not overwritten
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("held result dropped");

endmodule

// File: bench/tb_rle_pixel_decoder_unit.sv
// Testbench for rle_pixel_decoder_unit: directed and random run-length streams,
// checked item by item against an in-bench decoder with random idles on both sides.
// Depends on rpd_pkg and the rle_pixel_decoder_unit RTL.
`timescale 1ns / 1ps

module tb_rle_pixel_decoder_unit;
   import rpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 1600;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef enum logic [1:0] {DEC_HEADER, DEC_LITERAL, DEC_RUN, DEC_STOPPED} dec_phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } stream_item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [REPEAT_W-1:0] count;
      logic                done;
      logic [STATUS_W-1:0] status;
   } pixel_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_op = OP_DATA;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]   rsp_pixel_value;
   logic [REPEAT_W-1:0]  rsp_repeat_count;
   logic                 rsp_image_done;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BYTES_PER_PIXEL;
   logic [COUNT_W-1:0]   csr_data = '0;

   rle_pixel_decoder_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_status       (rsp_status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // decoder copy used for prediction
   logic [BPP_W-1:0]   cfg_bpp;
   logic [COUNT_W-1:0] cfg_pixels;
   logic [COUNT_W-1:0] cfg_limit;
   dec_phase_type      dec_phase;
   logic [7:0]         packet_left;
   logic [1:0]         byte_slot;
   logic [PIXEL_W-1:0] pixel_acc;
   logic [COUNT_W-1:0] pixels_done;
   logic [COUNT_W-1:0] bytes_seen;
   logic               clipped;

   stream_item_type  stream_bytes[$];
   pixel_result_type expected_pixels[$];

   bit          byte_on_bus = 1'b0;
   bit          sender_calm = 1'b0;
   bit          receiver_calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned items_queued = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned run_results = 0;
   int unsigned overruns = 0;
   int unsigned clipped_results = 0;
   int unsigned images_done = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   function automatic void clear_decoder();
      dec_phase   = DEC_HEADER;
      packet_left = '0;
      byte_slot   = '0;
      pixel_acc   = '0;
      pixels_done = '0;
      bytes_seen  = '0;
      clipped     = 1'b0;
   endfunction

   function automatic void decode_byte(input logic op, input logic [7:0] b);
      pixel_result_type   res;
      logic [7:0]         cnt;
      logic [COUNT_W-1:0] missing;
      logic [COUNT_W:0]   total;
      int unsigned        width;
      if (op == OP_START) begin
         clear_decoder();
         return;
      end
      if (dec_phase == DEC_STOPPED || pixels_done >= cfg_pixels)
         return;
      if ({1'b0, bytes_seen} + 33'd1 > {1'b0, cfg_limit}) begin
         dec_phase  = DEC_STOPPED;
         res.pixel  = '0;
         res.count  = '0;
         res.done   = 1'b0;
         res.status = ST_OVERRUN;
         expected_pixels.push_back(res);
         return;
      end
      bytes_seen++;

      if (dec_phase == DEC_HEADER) begin
         cnt = (b & HDR_LEN_MASK) + 8'd1;
         missing = cfg_pixels - pixels_done;
         clipped = 1'b0;
         if (32'(cnt) > missing) begin
            cnt = missing[7:0];
            clipped = 1'b1;
         end
         packet_left = cnt;
         byte_slot   = '0;
         pixel_acc   = '0;
         dec_phase   = ((b & HDR_RUN_BIT) != 0) ? DEC_RUN : DEC_LITERAL;
         return;
      end

      pixel_acc = pixel_acc | (32'(b) << {byte_slot, 3'b000});
      byte_slot = byte_slot + 2'd1;
      width = (cfg_bpp == 3'd0) ? 1 : (cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp);
      if (byte_slot != 0 && byte_slot < width)
         return;

      if (dec_phase == DEC_RUN) begin
         res.count = packet_left;
         packet_left = '0;
      end else begin
         res.count = 8'd1;
         if (packet_left != 0)
            packet_left--;
      end
      total = {1'b0, pixels_done} + 33'(res.count);
      pixels_done = total[COUNT_W] ? '1 : total[COUNT_W-1:0];

      res.pixel  = pixel_acc;
      res.status = clipped ? ST_CLIPPED : ST_OK;
      res.done   = 1'b0;
      if (pixels_done >= cfg_pixels) begin
         res.done = 1'b1;
         dec_phase = DEC_STOPPED;
      end else if (packet_left == 0) begin
         dec_phase = DEC_HEADER;
         clipped = 1'b0;
      end
      expected_pixels.push_back(res);
      pixel_acc = '0;
      byte_slot = '0;
   endfunction

   // sender: one item from the pending queue at a time, random gap after each accept
   always @(posedge clock) begin
      stream_item_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_byte(req_op, req_data_byte);
            items_sent++;
            send_gap = sender_calm ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 47) == 0)
               sender_calm = !sender_calm;
            byte_on_bus = 1'b0;
         end
         if (!byte_on_bus) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (stream_bytes.size() != 0) begin
               nxt = stream_bytes.pop_front();
               req_op        <= nxt.op;
               req_data_byte <= nxt.data;
               byte_on_bus = 1'b1;
            end
         end
         req_valid <= byte_on_bus;
      end
   end

   // receiver: check each accepted result, then stall for a random count
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: unexpected result pixel=%h count=%0d done=%0b status=%0d",
                           rsp_pixel_value, rsp_repeat_count, rsp_image_done, rsp_status);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_value !== want.pixel || rsp_repeat_count !== want.count ||
                   rsp_image_done !== want.done || rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"ERROR: result %0d expected pixel=%h count=%0d done=%0b ",
                               "status=%0d, got pixel=%h count=%0d done=%0b status=%0d"},
                              results_seen, want.pixel, want.count, want.done, want.status,
                              rsp_pixel_value, rsp_repeat_count, rsp_image_done, rsp_status);
               end
               if (want.count > 1) run_results++;
               if (want.status == ST_OVERRUN) overruns++;
               if (want.status == ST_CLIPPED) clipped_results++;
               if (want.done) images_done++;
            end
            stall_left = receiver_calm ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0)
               receiver_calm = !receiver_calm;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_pixels.size());
         $display("tb_rle_pixel_decoder_unit NOT OK");
         $finish;
      end
   end

   function automatic void push_item(input logic op, input logic [7:0] data);
      stream_item_type it;
      it.op = op;
      it.data = data;
      stream_bytes.push_back(it);
      items_queued++;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_BYTES_PER_PIXEL: cfg_bpp = val[BPP_W-1:0];
         CSR_IMAGE_PIXELS:    cfg_pixels = val;
         CSR_SOURCE_LIMIT:    cfg_limit = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // block is idle once nothing is pending or owed
   task automatic wait_idle();
      while (stream_bytes.size() != 0 || byte_on_bus || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one image: start, then mostly well-formed packets, now and then a cut-short one, then up to two stray bytes
   task automatic queue_image();
      int unsigned width, got, used, len, k;
      logic [7:0]  hdr;
      width = (cfg_bpp == 3'd0) ? 1 : (cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp);
      push_item(OP_START, 8'($urandom));
      got = 0;
      used = 0;
      while (got < cfg_pixels && used < 160) begin
         hdr = 8'($urandom);
         if ($urandom_range(0, 7) != 0)
            hdr[6:0] = 7'($urandom_range(0, 11));
         len = int'(hdr[6:0]) + 1;
         k = hdr[7] ? width : len * width;
         if ($urandom_range(0, 24) == 0)
            k = $urandom_range(0, k - 1);
         push_item(OP_DATA, hdr);
         repeat (k) push_item(OP_DATA, 8'($urandom));
         got += len;
         used += k + 1;
      end
      repeat ($urandom_range(0, 2)) push_item(OP_DATA, 8'($urandom));
   endtask

   initial begin
      logic [COUNT_W-1:0] val;
      int unsigned        goal;
      cfg_bpp    = BPP_RESET;
      cfg_pixels = PIXELS_RESET;
      cfg_limit  = LIMIT_RESET;
      clear_decoder();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero-pixel image, bytes are dropped
      push_item(OP_DATA, 8'h81);
      push_item(OP_DATA, 8'h12);
      wait_idle();

      // literal packet, then a maximal run clipped at the image end
      write_csr(CSR_BYTES_PER_PIXEL, 32'd1);
      write_csr(CSR_IMAGE_PIXELS, 32'd20);
      write_csr(CSR_SOURCE_LIMIT, 32'd1000);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'h02);
      push_item(OP_DATA, 8'h00);
      push_item(OP_DATA, 8'hff);
      push_item(OP_DATA, 8'ha5);
      push_item(OP_DATA, 8'hff);
      push_item(OP_DATA, 8'h5a);
      wait_idle();

      // source overrun, then bytes while stopped
      write_csr(CSR_BYTES_PER_PIXEL, 32'd2);
      write_csr(CSR_IMAGE_PIXELS, 32'd5);
      write_csr(CSR_SOURCE_LIMIT, 32'd5);
      push_item(OP_START, 8'hff);
      push_item(OP_DATA, 8'h80);
      push_item(OP_DATA, 8'h01);
      push_item(OP_DATA, 8'h02);
      push_item(OP_DATA, 8'h00);
      push_item(OP_DATA, 8'hff);
      push_item(OP_DATA, 8'hab);
      push_item(OP_DATA, 8'h11);
      wait_idle();

      // out-of-range width acts as 4; image shrunk in the middle of a packet
      write_csr(CSR_BYTES_PER_PIXEL, 32'd7);
      write_csr(CSR_IMAGE_PIXELS, 32'd100);
      write_csr(CSR_SOURCE_LIMIT, 32'hffff_ffff);
      push_item(OP_START, 8'h00);
      push_item(OP_DATA, 8'h01);
      repeat (4) push_item(OP_DATA, 8'($urandom));
      wait_idle();
      write_csr(CSR_IMAGE_PIXELS, 32'd2);
      repeat (4) push_item(OP_DATA, 8'($urandom));
      wait_idle();

      goal = items_queued + RANDOM_ITEMS;
      while (items_queued < goal) begin
         val = $urandom;
         val[BPP_W-1:0] = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7))
                                                      : 3'($urandom_range(1, 4));
         write_csr(CSR_BYTES_PER_PIXEL, val);
         case ($urandom_range(0, 11))
            0:       val = '0;
            1:       val = '1;
            2:       val = $urandom;
            default: val = $urandom_range(1, 40);
         endcase
         write_csr(CSR_IMAGE_PIXELS, val);
         case ($urandom_range(0, 9))
            0:       val = $urandom_range(0, 30);
            1:       val = '1;
            2:       val = $urandom;
            default: val = $urandom_range(100, 600);
         endcase
         write_csr(CSR_SOURCE_LIMIT, val);
         repeat ($urandom_range(1, 3)) queue_image();
         wait_idle();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d items; checked %0d results: %0d runs, %0d overruns, %0d clipped,",
               items_sent, results_seen, run_results, overruns, clipped_results);
      $display("%0d images completed, %0d mismatches", images_done, mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("tb_rle_pixel_decoder_unit OK");
      else
         $display("tb_rle_pixel_decoder_unit NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_core.sv
hw/rtl/rle_pixel_decoder_unit.sv
bench/tb_rle_pixel_decoder_unit.sv
